// ===== hw/rtl/ptdt_pkg.sv =====
// ============================================================================
// ptdt_pkg
// Shared types, codes and sizing for the priority timer dispatch table.
// ============================================================================
package ptdt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // one day in milliseconds
    localparam logic [31:0] HORIZON_TICKS = 32'd86400000;

    localparam logic [1:0] ACT_ADD      = 2'd0;
    localparam logic [1:0] ACT_REARM    = 2'd1;
    localparam logic [1:0] ACT_DISPATCH = 2'd2;

    typedef enum logic [2:0] {
        KIND_DUE       = 3'd0,
        KIND_WAKE      = 3'd1,
        KIND_NOTIMEOUT = 3'd2,
        KIND_DONE      = 3'd3,
        KIND_REJECT    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAKE
    } state_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  handler_id;
        logic [7:0]  priority_req;
        logic [31:0] activation_tick;
        logic [31:0] current_tick;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  due_handler;
        logic [31:0] wakeup_tick;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0]  prio;
        logic [7:0]  id;
        logic [31:0] activation;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic rearm;
        logic rotate;
    } cell_ctrl_t;

    typedef struct packed {
        logic init;
        logic step_en;
        logic step_occ;
    } wake_ctrl_t;

endpackage

// ===== hw/rtl/ptdt_cell.sv =====
// ============================================================================
// ptdt_cell
// One table slot: sorted insert from the left, rotate from the right, rearm.
// ============================================================================
module ptdt_cell (
    input  logic                 aclk,
    input  ptdt_pkg::cell_ctrl_t ctrl,
    input  ptdt_pkg::entry_t     new_entry,
    input  ptdt_pkg::entry_t     prev_entry,
    input  logic                 prev_keep,
    input  ptdt_pkg::entry_t     next_entry,
    input  logic                 occ,
    output ptdt_pkg::entry_t     entry,
    output logic                 keep,
    output logic                 match
);

    ptdt_pkg::entry_t entry_reg;
    ptdt_pkg::entry_t entry_next;

    // slot stays put on insert when it holds an equal or higher priority
    assign keep  = occ && (entry_reg.prio >= new_entry.prio);
    assign match = occ && (entry_reg.id == new_entry.id);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.insert) begin
            if (!keep) begin
                entry_next = prev_keep ? new_entry : prev_entry;
            end
        end else if (ctrl.rotate) begin
            entry_next = next_entry;
        end else if (ctrl.rearm && match) begin
            entry_next.activation = new_entry.activation;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hw/rtl/ptdt_wake.sv =====
// ============================================================================
// ptdt_wake
// Wake-up accumulator: running minimum of activations seen during a scan.
// ============================================================================
module ptdt_wake (
    input  logic                 aclk,
    input  ptdt_pkg::wake_ctrl_t ctrl,
    input  logic [31:0]          now_tick,
    input  logic [31:0]          activation,
    output logic                 due,
    output logic [31:0]          wakeup_tick
);

    logic [31:0] now_reg;
    logic [31:0] now_next;
    logic [31:0] min_reg;
    logic [31:0] min_next;
    logic [32:0] horizon_sum;

    assign horizon_sum = {1'b0, now_tick} + {1'b0, ptdt_pkg::HORIZON_TICKS};
    assign due         = activation < now_reg;
    assign wakeup_tick = (min_reg < now_reg) ? now_reg : min_reg;

    always_comb begin
        now_next = now_reg;
        min_next = min_reg;
        if (ctrl.init) begin
            now_next = now_tick;
            // saturate at the top of the tick range
            min_next = horizon_sum[32] ? 32'hFFFF_FFFF : horizon_sum[31:0];
        end else if (ctrl.step_en && ctrl.step_occ && (activation < min_reg)) begin
            min_next = activation;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg <= now_next;
        min_reg <= min_next;
    end

endmodule

// ===== hw/rtl/priority_timer_dispatch_table.sv =====
// ============================================================================
// priority_timer_dispatch_table
// Handler table sorted by descending priority, held in a row of cells, with
// add, rearm and dispatch transactions and a next wake-up tick report.
// ============================================================================
//
//  channel | dir | payload  | role
//  --------+-----+----------+-------------------------------------------
//  s_      | in  | item_t   | add / rearm / dispatch request transaction
//  m_      | out | result_t | result transactions, last marks the final one
//
//  add, rearm and unused codes give one result each; the insert is a
//  single shift across the row of cells
//  dispatch on a non-empty table rotates the whole row through cell 0, one
//  slot per cycle, then reports the wake-up tick; a busy output register
//  holds the rotation in place until it drains
//  reset clears the entry count and the sequencer; slot contents are only
//  read below the count and need no reset
//
module priority_timer_dispatch_table (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptdt_pkg::item_t   s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output ptdt_pkg::result_t m_result
);

    localparam int DEPTH = ptdt_pkg::TABLE_DEPTH;
    localparam int CW    = ptdt_pkg::CNT_W;

    // control state
    ptdt_pkg::state_t  state_reg;
    ptdt_pkg::state_t  state_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     step_reg;
    logic [CW-1:0]     step_next;

    // output register
    logic              m_valid_reg;
    ptdt_pkg::result_t m_result_reg;
    ptdt_pkg::result_t res;
    logic              load;

    logic              out_free;
    logic              accept;
    logic              full;
    logic              empty;
    logic              last_step;
    logic              step_occ;
    logic              any_match;

    ptdt_pkg::cell_ctrl_t cell_ctrl;
    ptdt_pkg::wake_ctrl_t wake_ctrl;
    ptdt_pkg::entry_t     new_entry;
    ptdt_pkg::entry_t     cell_entry [DEPTH];
    logic [DEPTH-1:0]     cell_keep;
    logic [DEPTH-1:0]     cell_match;
    logic [DEPTH-1:0]     cell_occ;

    logic                 due;
    logic [31:0]          wakeup_tick;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ptdt_pkg::ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign full      = count_reg == CW'(DEPTH);
    assign empty     = count_reg == '0;
    assign last_step = step_reg == CW'(DEPTH - 1);
    assign step_occ  = step_reg < count_reg;
    assign any_match = |cell_match;

    assign new_entry.prio       = s_item.priority_req;
    assign new_entry.id         = s_item.handler_id;
    assign new_entry.activation = s_item.activation_tick;

    // row of cells: insert shifts toward the tail, rotate toward cell 0
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_occ[i] = CW'(i) < count_reg;

        ptdt_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .new_entry  (new_entry),
            .prev_entry ((i == 0) ? new_entry : cell_entry[(i + DEPTH - 1) % DEPTH]),
            .prev_keep  ((i == 0) ? 1'b1 : cell_keep[(i + DEPTH - 1) % DEPTH]),
            .next_entry (cell_entry[(i + 1) % DEPTH]),
            .occ        (cell_occ[i]),
            .entry      (cell_entry[i]),
            .keep       (cell_keep[i]),
            .match      (cell_match[i])
        );
    end

    // cell 0 is the head of the scan
    ptdt_wake u_wake (
        .aclk        (aclk),
        .ctrl        (wake_ctrl),
        .now_tick    (s_item.current_tick),
        .activation  (cell_entry[0].activation),
        .due         (due),
        .wakeup_tick (wakeup_tick)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptdt_pkg::ST_IDLE: begin
                if (accept && (s_item.action == ptdt_pkg::ACT_DISPATCH) && !empty) begin
                    state_next = ptdt_pkg::ST_SCAN;
                end
            end
            ptdt_pkg::ST_SCAN: begin
                if (out_free && last_step) begin
                    state_next = ptdt_pkg::ST_WAKE;
                end
            end
            ptdt_pkg::ST_WAKE: begin
                if (out_free) begin
                    state_next = ptdt_pkg::ST_IDLE;
                end
            end
            default: state_next = ptdt_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        cell_ctrl  = '0;
        wake_ctrl  = '0;
        load       = 1'b0;
        res        = '{kind: ptdt_pkg::KIND_DONE, due_handler: 8'd0,
                       wakeup_tick: 32'd0, last: 1'b1};
        count_next = count_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ptdt_pkg::ST_IDLE: begin
                step_next = '0;
                if (accept) begin
                    load = 1'b1;
                    unique case (s_item.action)
                        ptdt_pkg::ACT_ADD: begin
                            if (full) begin
                                res.kind = ptdt_pkg::KIND_REJECT;
                            end else begin
                                cell_ctrl.insert = 1'b1;
                                count_next       = count_reg + 1'b1;
                            end
                        end
                        ptdt_pkg::ACT_REARM: begin
                            cell_ctrl.rearm = 1'b1;
                            if (!any_match) begin
                                res.kind = ptdt_pkg::KIND_REJECT;
                            end
                        end
                        ptdt_pkg::ACT_DISPATCH: begin
                            if (empty) begin
                                res.kind = ptdt_pkg::KIND_NOTIMEOUT;
                            end else begin
                                load           = 1'b0;
                                wake_ctrl.init = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ptdt_pkg::ST_SCAN: begin
                if (out_free) begin
                    cell_ctrl.rotate   = 1'b1;
                    wake_ctrl.step_en  = 1'b1;
                    wake_ctrl.step_occ = step_occ;
                    step_next          = step_reg + 1'b1;
                    if (step_occ && due) begin
                        load            = 1'b1;
                        res.kind        = ptdt_pkg::KIND_DUE;
                        res.due_handler = cell_entry[0].id;
                        res.last        = 1'b0;
                    end
                end
            end
            ptdt_pkg::ST_WAKE: begin
                if (out_free) begin
                    load            = 1'b1;
                    res.kind        = ptdt_pkg::KIND_WAKE;
                    res.wakeup_tick = wakeup_tick;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ptdt_pkg::ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_result_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule

// ===== test/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for priority_timer_dispatch_table: add, rearm, dispatch
// and unused transactions are predicted against a local copy of the handler
// table, under phases of source idling, sink stalls and long sink hold-off.
// ============================================================================
module testbench;
    import ptdt_pkg::*;

    // the fourth action code has no meaning and just returns done
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // ------------------------------------------------------------------------
    // scoreboard: local handler table plus the queue of awaited results
    // ------------------------------------------------------------------------
    class dispatch_scoreboard;
        entry_t      slots[TABLE_DEPTH];
        int unsigned fill;
        result_t     awaited[$];
        int unsigned errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void push_result(kind_t kind, logic [7:0] id, logic [31:0] tick,
                                  logic last);
            result_t r;
            r.kind        = kind;
            r.due_handler = id;
            r.wakeup_tick = tick;
            r.last        = last;
            awaited.push_back(r);
        endfunction

        // work out the results of an accepted request and update the table
        function void note_item(item_t it);
            int unsigned pos;
            int unsigned i;
            logic        found;
            logic [31:0] wake;
            case (it.action)
                ACT_ADD: begin
                    if (fill >= TABLE_DEPTH) begin
                        push_result(KIND_REJECT, 8'd0, 32'd0, 1'b1);
                    end else begin
                        pos = 0;
                        while (pos < fill && slots[pos].prio >= it.priority_req)
                            pos++;
                        for (i = fill; i > pos; i--)
                            slots[i] = slots[i - 1];
                        slots[pos].prio       = it.priority_req;
                        slots[pos].id         = it.handler_id;
                        slots[pos].activation = it.activation_tick;
                        fill++;
                        push_result(KIND_DONE, 8'd0, 32'd0, 1'b1);
                    end
                end
                ACT_REARM: begin
                    found = 1'b0;
                    for (i = 0; i < fill; i++) begin
                        if (slots[i].id == it.handler_id) begin
                            slots[i].activation = it.activation_tick;
                            found = 1'b1;
                        end
                    end
                    push_result(found ? KIND_DONE : KIND_REJECT, 8'd0, 32'd0, 1'b1);
                end
                ACT_DISPATCH: begin
                    if (fill == 0) begin
                        push_result(KIND_NOTIMEOUT, 8'd0, 32'd0, 1'b1);
                    end else begin
                        // horizon saturates at the top of the tick range
                        if (it.current_tick > 32'hFFFF_FFFF - HORIZON_TICKS)
                            wake = 32'hFFFF_FFFF;
                        else
                            wake = it.current_tick + HORIZON_TICKS;
                        for (i = 0; i < fill; i++)
                            if (slots[i].activation < wake)
                                wake = slots[i].activation;
                        if (wake < it.current_tick)
                            wake = it.current_tick;
                        for (i = 0; i < fill; i++)
                            if (slots[i].activation < it.current_tick)
                                push_result(KIND_DUE, slots[i].id, 32'd0, 1'b0);
                        push_result(KIND_WAKE, 8'd0, wake, 1'b1);
                    end
                end
                default: push_result(KIND_DONE, 8'd0, 32'd0, 1'b1);
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                flag($sformatf("unexpected result kind %0d id %0h tick %0h last %0b",
                               got.kind, got.due_handler, got.wakeup_tick, got.last));
            end else begin
                want = awaited.pop_front();
                if (got.kind !== want.kind || got.due_handler !== want.due_handler ||
                    got.wakeup_tick !== want.wakeup_tick || got.last !== want.last)
                    flag($sformatf({"mismatch: expected kind %0d id %0h tick %0h last %0b,",
                                    " got kind %0d id %0h tick %0h last %0b"},
                                   want.kind, want.due_handler, want.wakeup_tick,
                                   want.last, got.kind, got.due_handler,
                                   got.wakeup_tick, got.last));
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the block under test
    // ------------------------------------------------------------------------
    logic    aclk    = 1'b0;
    logic    aresetn = 1'b0;
    logic    s_valid = 1'b0;
    logic    s_ready;
    item_t   s_item  = '0;
    logic    m_valid;
    logic    m_ready = 1'b0;
    result_t m_result;

    dispatch_scoreboard sb = new();

    // idling knobs, percent of cycles
    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    // long hold-off request from the driver, picked up by the sink process
    int unsigned hold_len = 0;
    int unsigned hold_cnt = 0;
    // tick neighborhood around which most activations and dispatch times fall
    logic [31:0] tick_base;

    always #5 aclk = ~aclk;

    priority_timer_dispatch_table u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    // ------------------------------------------------------------------------
    // sink: random stalls, or a counted hold-off when the driver asks for one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_len != 0) begin
            hold_cnt = hold_len;
            hold_len = 0;
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // result monitor: every accepted result transaction is checked in order
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_result);
    end

    // ------------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------------

    // offer one request transaction, with a random gap in front of it
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        // valid stays up with the payload held until the block takes it
        do @(posedge aclk); while (!s_ready);
        sb.note_item(it);
    endtask

    // sender pause: nothing offered until every awaited result has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    function automatic item_t make_item(logic [1:0] action, logic [7:0] id,
                                        logic [7:0] prio, logic [31:0] act,
                                        logic [31:0] now);
        item_t it;
        it.action          = action;
        it.handler_id      = id;
        it.priority_req    = prio;
        it.activation_tick = act;
        it.current_tick    = now;
        return it;
    endfunction

    function automatic logic [31:0] near_base();
        return tick_base + $urandom_range(4000) - 32'd2000;
    endfunction

    // random request, weighted toward rearm and dispatch on the live table
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick;
        int unsigned slot;
        it.action          = ACT_UNUSED;
        it.handler_id      = 8'($urandom_range(255));
        it.priority_req    = 8'($urandom_range(255));
        it.activation_tick = $urandom;
        it.current_tick    = $urandom;
        slot = (sb.fill == 0) ? 0 : $urandom_range(sb.fill - 1);
        // let the time base drift forward now and then
        if ($urandom_range(3) == 0)
            tick_base = tick_base + $urandom_range(1500);
        pick = $urandom_range(99);
        if (pick < 10) begin
            it.action = ACT_ADD;
        end else if (pick < 45) begin
            it.action = ACT_REARM;
            if (sb.fill != 0 && $urandom_range(9) < 8)
                it.handler_id = sb.slots[slot].id;
            case ($urandom_range(9))
                0:       it.activation_tick = $urandom;
                1:       it.activation_tick = 32'd0;
                2:       it.activation_tick = 32'hFFFF_FFFF;
                default: it.activation_tick = near_base();
            endcase
        end else if (pick < 90) begin
            it.action = ACT_DISPATCH;
            case ($urandom_range(9))
                0:       it.current_tick = $urandom;
                1:       it.current_tick = 32'hFFFF_FFFF - $urandom_range(HORIZON_TICKS);
                2:       it.current_tick = sb.slots[slot].activation + $urandom_range(1);
                3:       it.current_tick = 32'd0;
                default: it.current_tick = near_base();
            endcase
        end
        return it;
    endfunction

    task automatic run_random(input int unsigned count);
        repeat (count) send_item(random_item());
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        tick_base = $urandom;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table corner cases first
        send_item(make_item(ACT_DISPATCH, 8'h00, 8'h00, 32'h0, 32'hFFFF_FFFF));
        send_item(make_item(ACT_REARM, 8'h11, 8'h00, 32'h1234, 32'h0));
        send_item(make_item(ACT_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

        // equal priorities keep arrival order, extremes of priority and tick
        send_item(make_item(ACT_ADD, 8'h10, 8'd100, 32'd1000, 32'h0));
        send_item(make_item(ACT_ADD, 8'h20, 8'd100, 32'd500, 32'h0));
        send_item(make_item(ACT_ADD, 8'h30, 8'd255, 32'hFFFF_FFFF, 32'h0));
        send_item(make_item(ACT_ADD, 8'h40, 8'd0, 32'd0, 32'h0));
        // duplicate id at a lower priority
        send_item(make_item(ACT_ADD, 8'h20, 8'd50, 32'd2000, 32'h0));

        // some due, wake-up raised to now; activation equal to now is not due
        send_item(make_item(ACT_DISPATCH, 8'h00, 8'h00, 32'h0, 32'd1000));
        // rearm hits both entries sharing the id
        send_item(make_item(ACT_REARM, 8'h20, 8'h00, 32'd5, 32'h0));
        // horizon overflow near the top of the tick range
        send_item(make_item(ACT_DISPATCH, 8'h00, 8'h00, 32'h0, 32'hFFFF_FFF0));
        // nothing due at tick zero
        send_item(make_item(ACT_DISPATCH, 8'h00, 8'h00, 32'h0, 32'd0));
        // rearm of an id that is not in the table
        send_item(make_item(ACT_REARM, 8'hFF, 8'h00, 32'd7, 32'h0));

        // fill the table with random content, then one add too many
        while (sb.fill < TABLE_DEPTH)
            send_item(make_item(ACT_ADD, 8'($urandom_range(255)), 8'($urandom_range(255)),
                                near_base(), 32'h0));
        send_item(make_item(ACT_ADD, 8'hFF, 8'hFF, 32'h0, 32'h0));
        // full table dispatch at the last tick: entries activated before it are due
        send_item(make_item(ACT_DISPATCH, 8'h00, 8'h00, 32'h0, 32'hFFFF_FFFF));

        // phase: no idling on either side
        run_random(90);

        // sink holds off a long stretch while the source keeps offering
        hold_len = 400;
        run_random(30);
        drain();

        // phase: source idle most of the time
        src_idle_pct = 64;
        run_random(90);

        // phase: sink stalling most of the time
        src_idle_pct   = 0;
        sink_stall_pct = 64;
        run_random(90);

        // phase: light idling on both sides
        src_idle_pct   = 19;
        sink_stall_pct = 19;
        run_random(90);

        // wind down: wait for the last results, then a few more cycles
        s_valid <= 1'b0;
        sink_stall_pct = 0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (2 * TABLE_DEPTH + 4) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #4000000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== priority_timer_dispatch_table.f =====
hw/rtl/ptdt_pkg.sv
hw/rtl/ptdt_cell.sv
hw/rtl/ptdt_wake.sv
hw/rtl/priority_timer_dispatch_table.sv
test/testbench.sv
